@@ hw/rtl/b32dec_pkg.sv @@
// ----------------------------------------------------------------------------
// b32dec_pkg
// Character classes and the base32 alphabet map for the text decoder.
// ----------------------------------------------------------------------------
package b32dec_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SymW   = 5;
  localparam int unsigned HeldW  = 3;   // pending bit count never exceeds 7
  localparam int unsigned StoreW = 7;   // at most seven pending bits
  localparam int unsigned AccW   = StoreW + SymW;

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;
  localparam logic [CharW-1:0] ChHyphen = 8'h2D;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChOne    = 8'h31;
  localparam logic [CharW-1:0] ChTwo    = 8'h32;
  localparam logic [CharW-1:0] ChSeven  = 8'h37;
  localparam logic [CharW-1:0] ChEight  = 8'h38;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpB    = 8'h42;
  localparam logic [CharW-1:0] ChUpL    = 8'h4C;
  localparam logic [CharW-1:0] ChUpO    = 8'h4F;
  localparam logic [CharW-1:0] ChUpZ    = 8'h5A;
  localparam logic [CharW-1:0] ChLoA    = 8'h61;
  localparam logic [CharW-1:0] ChLoZ    = 8'h7A;

  // Offset from the low five bits of '2'..'7' to symbol values 26..31.
  localparam logic [SymW-1:0] DigitOfs = 5'd8;

  typedef struct packed {
    logic            ok;
    logic [SymW-1:0] value;
  } sym_t;

  function automatic logic is_skip(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) ||
           (c == ChLf) || (c == ChHyphen);
  endfunction

  function automatic sym_t map_char(input logic [CharW-1:0] c_in);
    logic [CharW-1:0] c;
    sym_t             s;
    c = c_in;
    if (c_in == ChZero) c = ChUpO;
    else if (c_in == ChOne) c = ChUpL;
    else if (c_in == ChEight) c = ChUpB;
    s.ok    = 1'b0;
    s.value = '0;
    if ((c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ)) begin
      s.ok    = 1'b1;
      s.value = c[SymW-1:0] - SymW'(1);
    end else if (c >= ChTwo && c <= ChSeven) begin
      s.ok    = 1'b1;
      s.value = c[SymW-1:0] + DigitOfs;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/base32_text_decoder.sv @@
// ----------------------------------------------------------------------------
// base32_text_decoder
// Streaming base32 text decoder: one character in, one result out per
// transaction. An accepted character waits in the input stage, then its
// result is registered in the output register and held there while stalled.
// Throughput: one character per cycle while the output is not stalled;
// the pending-bit buffer is updated as each character advances.
// Reset (rst, synchronous): clears both stages, the bit buffer and the error.
// ----------------------------------------------------------------------------
module base32_text_decoder
  import b32dec_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // character channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CharW-1:0] in_char,
  input  logic             string_last,
  // byte channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       data_byte,
  output logic             byte_valid,
  output logic             bad_char,
  output logic             string_end
);

  // Input stage: holds one character so a new transaction can land while
  // the output register still waits on the consumer.
  logic             iv;
  logic [CharW-1:0] ichar;
  logic             ilast;

  // Decoder state: pending bits and the sticky error for the current string.
  logic [StoreW-1:0] bit_store, bit_store_next;
  logic [HeldW-1:0]  bits_held, bits_held_next;
  logic              error_seen, error_seen_next;

  logic        out_free;
  logic        advance;
  logic        in_take;
  logic [7:0]  byte_next;
  logic        bvalid_next;

  // Output register frees up when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  assign advance  = iv && out_free;
  assign in_stall = iv && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Single-pass update: classify, map, append five bits, maybe emit a byte.
  always_comb begin
    sym_t            sym;
    logic [AccW-1:0] acc;
    logic [HeldW:0]  sum;
    logic [HeldW-1:0] rem;
    logic [AccW-1:0] shifted;
    logic [StoreW-1:0] keep;

    sym     = map_char(ichar);
    acc     = {bit_store, sym.value};
    sum     = {1'b0, bits_held} + (HeldW+1)'(SymW);
    rem     = sum[HeldW-1:0];          // sum - 8 when sum >= 8
    shifted = acc >> rem;
    keep    = StoreW'((AccW'(1) << rem) - AccW'(1));

    bit_store_next  = bit_store;
    bits_held_next  = bits_held;
    error_seen_next = error_seen;
    byte_next       = '0;
    bvalid_next     = 1'b0;

    if (!is_skip(ichar) && !error_seen) begin
      if (sym.ok) begin
        if (sum[HeldW]) begin
          // Eight or more bits held: emit the top byte, keep the rest.
          byte_next      = shifted[7:0];
          bvalid_next    = 1'b1;
          bits_held_next = rem;
          bit_store_next = acc[StoreW-1:0] & keep;
        end else begin
          bits_held_next = sum[HeldW-1:0];
          bit_store_next = acc[StoreW-1:0];
        end
      end else begin
        // Invalid character: flag the string, drop what was pending.
        error_seen_next = 1'b1;
        bit_store_next  = '0;
        bits_held_next  = '0;
      end
    end
  end

  // Input stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_take) begin
      iv <= 1'b1;
    end else if (advance) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ichar <= in_char;
      ilast <= string_last;
    end
  end

  // Decoder state: update on each advanced character, clear after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store  <= '0;
      bits_held  <= '0;
      error_seen <= 1'b0;
    end else if (advance) begin
      if (ilast) begin
        bit_store  <= '0;
        bits_held  <= '0;
        error_seen <= 1'b0;
      end else begin
        bit_store  <= bit_store_next;
        bits_held  <= bits_held_next;
        error_seen <= error_seen_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_byte  <= byte_next;
      byte_valid <= bvalid_next;
      bad_char   <= error_seen_next;
      string_end <= ilast;
    end
  end

endmodule

@@ hw/rtl/b32dec_checker.sv @@
// ----------------------------------------------------------------------------
// b32dec_checker
// Port-level checks for the base32 text decoder.
// ----------------------------------------------------------------------------
module b32dec_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       data_byte,
  input logic             byte_valid,
  input logic             bad_char,
  input logic             string_end
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;
  logic       err_open;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track transactions in flight and whether the current string has failed.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      err_open <= 1'b0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        err_open <= bad_char && !string_end;
      end
    end
  end

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an accepted character");

  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && err_open |-> bad_char)
    else $error("error flag dropped inside a failed string");

  a_no_byte_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> !byte_valid && data_byte == 8'd0)
    else $error("byte emitted while string is flagged bad");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output register");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) &&
      $stable(byte_valid) && $stable(bad_char) && $stable(string_end))
    else $error("stalled result changed");

endmodule

bind base32_text_decoder b32dec_checker u_b32dec_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .data_byte   (data_byte),
  .byte_valid  (byte_valid),
  .bad_char    (bad_char),
  .string_end  (string_end)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base32_text_decoder. A queue of text characters,
// directed strings first and then random well-formed, broken and noise
// strings, feeds a clocked driver. A built-in decoder predicts one result per
// accepted character, and a clocked monitor compares each output transaction
// field by field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import b32dec_pkg::*;

  localparam int unsigned TextChars  = 600;     // random characters, blanks not counted
  localparam int unsigned CycleLimit = 200000;  // far above the slowest legal run
  localparam int unsigned DrainWait  = 10;      // idle time after the last result is checked

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             tail;
  } text_char_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       bad_char;
    logic       string_end;
  } decode_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CharW-1:0] in_char = '0;
  logic             string_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       data_byte;
  logic             byte_valid;
  logic             bad_char;
  logic             string_end;

  // Characters waiting to be driven, and results predicted but not yet seen.
  text_char_t     char_queue[$];
  decode_result_t result_queue[$];

  // Predictor state: mirrors the pending-bit buffer of the decoder.
  logic [11:0] bit_store  = '0;
  logic [3:0]  bits_held  = '0;
  logic        error_seen = 1'b0;

  int unsigned chars_queued   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  bit          tx_calm        = 1'b0;
  bit          rx_calm        = 1'b0;
  bit          tx_busy;
  text_char_t  tx_next;
  decode_result_t seen;

  base32_text_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .string_last (string_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .bad_char    (bad_char),
    .string_end  (string_end)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // Whitespace and hyphen are dropped without touching the buffer.
  function automatic logic is_blank(input logic [CharW-1:0] c);
    case (c)
      ChSpace, ChTab, ChCr, ChLf, ChHyphen: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Return {ok, value}; ok is low for a character outside the alphabet.
  function automatic logic [SymW:0] symbol_of(input logic [CharW-1:0] c_in);
    logic [CharW-1:0] c;
    c = c_in;
    // fold the look-alike digits onto their letters
    case (c_in)
      ChZero:  c = ChUpO;
      ChOne:   c = ChUpL;
      ChEight: c = ChUpB;
      default: c = c_in;
    endcase
    if ((c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ))
      return {1'b1, 5'(c[4:0] - 5'd1)};
    if (c >= ChTwo && c <= ChSeven)
      return {1'b1, 5'(c - (ChTwo - 8'd26))};
    return '0;
  endfunction

  // Advance the model by one character and return the result it yields.
  function automatic decode_result_t decode_step(input logic [CharW-1:0] c,
                                                 input logic tail);
    decode_result_t r;
    logic [SymW:0]  sym;
    logic [3:0]     rem;
    r = '0;
    if (!is_blank(c) && !error_seen) begin
      sym = symbol_of(c);
      if (sym[SymW]) begin
        // shift in five bits; the buffer never needs more than twelve
        bit_store = {bit_store[6:0], sym[SymW-1:0]};
        bits_held = bits_held + 4'd5;
        if (bits_held >= 4'd8) begin
          rem          = bits_held - 4'd8;
          r.data_byte  = 8'(bit_store >> rem);
          r.byte_valid = 1'b1;
          bits_held    = rem;
          bit_store    = bit_store & ((12'd1 << rem) - 12'd1);
        end
      end else begin
        // invalid character: poison the rest of the string
        error_seen = 1'b1;
        bit_store  = '0;
        bits_held  = '0;
      end
    end
    r.bad_char   = error_seen;
    r.string_end = tail;
    // end of string: drop leftover bits and the error
    if (tail) begin
      bit_store  = '0;
      bits_held  = '0;
      error_seen = 1'b0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int unsigned idle_length(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [CharW-1:0] alphabet_char();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return ChUpA + 8'($urandom_range(0, 25));
    if (roll < 7) return ChLoA + 8'($urandom_range(0, 25));
    if (roll < 9) return ChTwo + 8'($urandom_range(0, 5));
    case ($urandom_range(0, 2))
      0:       return ChZero;
      1:       return ChOne;
      default: return ChEight;
    endcase
  endfunction

  function automatic logic [CharW-1:0] blank_char();
    case ($urandom_range(0, 4))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChCr;
      3:       return ChLf;
      default: return ChHyphen;
    endcase
  endfunction

  function automatic logic [CharW-1:0] invalid_char();
    logic [CharW-1:0] c;
    logic [SymW:0]    sym;
    do begin
      c   = 8'($urandom_range(0, 255));
      sym = symbol_of(c);
    end while (sym[SymW] || is_blank(c));
    return c;
  endfunction

  task automatic push_char(input logic [CharW-1:0] c, input logic tail);
    text_char_t t;
    t.code = c;
    t.tail = tail;
    char_queue.push_back(t);
    if (!is_blank(c)) chars_queued++;
  endtask

  task automatic push_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], close && (i == s.len() - 1));
  endtask

  // Random string: well-formed text with stray blanks, a broken string with
  // one bad character, or raw noise over the full byte range.
  task automatic push_random_string();
    int unsigned kind;
    int unsigned len;
    int unsigned bad_pos;
    logic [CharW-1:0] c;
    kind    = $urandom_range(0, 99);
    len     = (kind < 85) ? $urandom_range(1, 16) : $urandom_range(1, 8);
    bad_pos = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if (kind >= 85)
        c = 8'($urandom_range(0, 255));
      else if (kind >= 70 && i == bad_pos)
        c = invalid_char();
      else if ($urandom_range(0, 99) < 8)
        c = blank_char();
      else
        c = alphabet_char();
      push_char(c, i == len - 1);
    end
  endtask

  // Hold until the driver is empty and every predicted result has arrived.
  task automatic wait_drained();
    while (char_queue.size() != 0 || in_valid || result_queue.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued characters, predict on each accepted transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      tx_busy = in_valid;
      if (in_valid && !in_stall) begin
        result_queue.push_back(decode_step(in_char, string_last));
        tx_busy = 1'b0;
      end
      // hold the payload while stalled; otherwise idle or advance
      if (!tx_busy) begin
        if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_queue.size() != 0) begin
          tx_next     = char_queue.pop_front();
          in_char     <= tx_next.code;
          string_last <= tx_next.tail;
          in_valid    <= 1'b1;
          send_gap    = idle_length(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each output transaction, then draw the next stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          $error("output transaction with no prediction pending");
          mismatch_count++;
        end else begin
          seen = result_queue.pop_front();
          if (data_byte !== seen.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", seen.data_byte, data_byte);
            mismatch_count++;
          end
          if (byte_valid !== seen.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", seen.byte_valid, byte_valid);
            mismatch_count++;
          end
          if (bad_char !== seen.bad_char) begin
            $error("bad_char: expected %0b, actual %0b", seen.bad_char, bad_char);
            mismatch_count++;
          end
          if (string_end !== seen.string_end) begin
            $error("string_end: expected %0b, actual %0b", seen.string_end, string_end);
            mismatch_count++;
          end
        end
      end
      if (stall_left == 0) begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        stall_left = idle_length(rx_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed strings, two random halves, drain
  // --------------------------------------------------------------------------
  initial begin
    string singles;
    singles = "9[`{:/";

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // letters of both cases, the extreme digits, space, tab and hyphen, the look-alike
    // digits; leftover bits are dropped at the end of the string
    push_text("Az27 \t-018", 1'b1);
    // CR/LF, then a bad character: everything after it stays flagged
    push_text("\r\nZa@B9", 1'b0);
    push_char(8'hFF, 1'b1);
    // a NUL, then lone bad characters just outside each alphabet range, each ending a string
    push_char(8'h00, 1'b1);
    for (int i = 0; i < singles.len(); i++)
      push_char(singles[i], 1'b1);

    // pause the sender until every directed result is back
    wait_drained();

    chars_queued = 0;
    while (chars_queued < TextChars / 2) push_random_string();
    wait_drained();
    while (chars_queued < TextChars) push_random_string();
    wait_drained();

    repeat (DrainWait) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/b32dec_pkg.sv
hw/rtl/base32_text_decoder.sv
hw/rtl/b32dec_checker.sv
dv/testbench.sv
